// ===== rtl/core/rrc_pkg.sv =====
package rrc_pkg;

  // Width of a byte address inside the image.
  localparam int ADDR_BITS = 24;

  // Widths of the configuration port.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = ADDR_BITS + 1;

  // Reflected CRC-32 polynomial and the all-ones preset / final xor.
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [31:0] HALF_MASK = 32'h0000_FFFF;

  // Register values after reset.
  localparam logic [ADDR_BITS-1:0] START_RESET = ADDR_BITS'(32'h0001_0000);
  localparam logic [ADDR_BITS:0]   END_RESET   = (ADDR_BITS + 1)'(32'h001F_0000);
  localparam logic [ADDR_BITS-1:0] STORE_RESET = ADDR_BITS'(32'h0001_FFF0);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_REGION_START  = 3'd0,
    REG_REGION_END    = 3'd1,
    REG_STORE_OFFSET  = 3'd2,
    REG_CHECKSUM_MODE = 3'd3,
    REG_BIG_ENDIAN    = 3'd4
  } cfg_reg_t;

  // Checksum modes.
  typedef enum logic [1:0] {
    MODE_SUM32 = 2'd0,
    MODE_SUM16 = 2'd1,
    MODE_XOR32 = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_END_PAST    = 3'd2,
    ST_STORE_PAST  = 3'd3,
    ST_TOO_LONG    = 3'd4
  } status_t;

  // One byte of the reflected CRC, bit by bit.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  // Place a byte at byte lane k of a 32-bit word.
  function automatic logic [31:0] place_byte(input logic [7:0] b, input logic [1:0] k);
    return {24'h0, b} << {k, 3'b000};
  endfunction

endpackage

// ===== rtl/core/rrc_image_if.sv =====
interface rrc_image_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_image;

  modport source (output valid, output data_byte, output end_of_image, input ready);
  modport sink (input valid, input data_byte, input end_of_image, output ready);
endinterface

// ===== rtl/core/rrc_result_if.sv =====
interface rrc_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] checksum_value;
  logic [31:0] crc_value;
  logic [31:0] stored_value;
  logic        checksum_matches;
  logic [2:0]  status;

  modport source (
    output valid, output checksum_value, output crc_value, output stored_value,
    output checksum_matches, output status, input ready
  );
  modport sink (
    input valid, input checksum_value, input crc_value, input stored_value,
    input checksum_matches, input status, output ready
  );
endinterface

// ===== rtl/core/rrc_cfg_if.sv =====
interface rrc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rrc_pkg::CFG_INDEX_BITS-1:0] index;
  logic [rrc_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rom_region_checksum_check_top.sv =====
// Region checksum checker. Image bytes arrive one per transfer on the image
// channel, addressed from zero; the byte flagged end_of_image closes the image
// and produces exactly one result transfer (checksum, CRC-32, stored word, match
// flag and status), after which the checker starts over for the next image.
// Throughput is one byte per clock unless a final byte waits: each byte is held
// in an input register, and the CRC, word assembly and accumulator update for it
// complete as it leaves that register into the image state or result register.
// Only a final byte waits, and only while the previous result is still held
// in the result register. Configuration writes are accepted at any time and
// should be made between images; the status reports, in priority order, an
// image longer than the address space, an empty region, a region end past the
// image and a stored word past the image, with all result values zero then.
module rom_region_checksum_check_top (
  input logic          clk,
  input logic          rst,
  rrc_image_if.sink    image,
  rrc_result_if.source result,
  rrc_cfg_if.sink      cfg
);

  localparam int A = rrc_pkg::ADDR_BITS;
  localparam logic [A:0] POS_LIMIT = {1'b1, {A{1'b0}}};

  // Configuration registers.
  logic [A-1:0]       region_start;
  logic [A:0]         region_end;
  logic [A-1:0]       store_offset;
  rrc_pkg::mode_t     checksum_mode;
  logic               big_endian;

  // Running state of the current image.
  logic [A:0]  byte_position, byte_position_next;
  logic [31:0] word_assembly, word_assembly_next;
  logic [31:0] checksum_acc, checksum_acc_next;
  logic [31:0] crc_reg, crc_reg_next;
  logic [31:0] stored_word, stored_word_next;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_fire;

  // Result register.
  logic             out_valid;
  logic [31:0]      out_checksum;
  logic [31:0]      out_crc;
  logic [31:0]      out_stored;
  logic             out_match;
  rrc_pkg::status_t out_status;
  logic             out_free;

  // Combinational result of the final byte.
  logic [31:0]      res_checksum, res_crc, res_stored;
  logic             res_match;
  rrc_pkg::status_t res_status;

  logic             in_region, in_store;
  logic [A:0]       store_end, image_size;
  logic [1:0]       region_lane, store_lane;

  // Configuration writes; indexes past the list are ignored.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start  <= rrc_pkg::START_RESET;
      region_end    <= rrc_pkg::END_RESET;
      store_offset  <= rrc_pkg::STORE_RESET;
      checksum_mode <= rrc_pkg::MODE_SUM32;
      big_endian    <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        rrc_pkg::REG_REGION_START:  region_start  <= cfg.data[A-1:0];
        rrc_pkg::REG_REGION_END:    region_end    <= cfg.data[A:0];
        rrc_pkg::REG_STORE_OFFSET:  store_offset  <= cfg.data[A-1:0];
        rrc_pkg::REG_CHECKSUM_MODE: checksum_mode <= rrc_pkg::mode_t'(cfg.data[1:0]);
        rrc_pkg::REG_BIG_ENDIAN:    big_endian    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Handshakes: a byte in the input register moves on unless it is final and
  // the result register is still occupied.
  assign out_free    = !out_valid || result.ready;
  assign s1_fire     = s1_valid && (!s1_last || out_free);
  assign image.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (image.ready) begin
      s1_valid <= image.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (image.valid && image.ready) begin
      s1_byte <= image.data_byte;
      s1_last <= image.end_of_image;
    end
  end

  // Address decode for the byte in the input register.
  assign in_region   = (byte_position >= {1'b0, region_start}) && (byte_position < region_end);
  assign store_end   = {1'b0, store_offset} + (A + 1)'(4);
  assign in_store    = (byte_position >= {1'b0, store_offset}) && (byte_position < store_end);
  assign region_lane = byte_position[1:0] - region_start[1:0];
  assign store_lane  = byte_position[1:0] - store_offset[1:0];

  // Next state for one byte: CRC, word assembly, accumulation, stored word.
  always_comb begin
    word_assembly_next = word_assembly;
    checksum_acc_next  = checksum_acc;
    crc_reg_next       = crc_reg;
    stored_word_next   = stored_word;
    if (!byte_position[A]) begin
      if (in_region) begin
        crc_reg_next = rrc_pkg::crc_byte(crc_reg, s1_byte);
        unique case (checksum_mode)
          rrc_pkg::MODE_SUM16: begin
            word_assembly_next = word_assembly | rrc_pkg::place_byte(
              s1_byte, {1'b0, region_lane[0] ^ big_endian});
            if (region_lane[0]) begin
              checksum_acc_next  = checksum_acc + word_assembly_next;
              word_assembly_next = '0;
            end
          end
          rrc_pkg::MODE_SUM32, rrc_pkg::MODE_XOR32: begin
            word_assembly_next = word_assembly | rrc_pkg::place_byte(
              s1_byte, big_endian ? ~region_lane : region_lane);
            if (region_lane == 2'd3) begin
              if (checksum_mode == rrc_pkg::MODE_SUM32) begin
                checksum_acc_next = checksum_acc + word_assembly_next;
              end else begin
                checksum_acc_next = checksum_acc ^ word_assembly_next;
              end
              word_assembly_next = '0;
            end
          end
          rrc_pkg::MODE_NONE: ;
          default: ;
        endcase
      end
      if (in_store) begin
        stored_word_next = stored_word | rrc_pkg::place_byte(
          s1_byte, big_endian ? ~store_lane : store_lane);
      end
    end
    byte_position_next = (byte_position <= POS_LIMIT) ? byte_position + 1'b1 : byte_position;
  end

  // Result of the final byte, checks in priority order.
  assign image_size = byte_position + 1'b1;

  always_comb begin
    priority if (byte_position[A]) begin
      res_status = rrc_pkg::ST_TOO_LONG;
    end else if ({1'b0, region_start} >= region_end) begin
      res_status = rrc_pkg::ST_EMPTY;
    end else if (region_end > image_size) begin
      res_status = rrc_pkg::ST_END_PAST;
    end else if (store_end > image_size) begin
      res_status = rrc_pkg::ST_STORE_PAST;
    end else begin
      res_status = rrc_pkg::ST_OK;
    end

    unique case (checksum_mode)
      rrc_pkg::MODE_SUM16: res_checksum = checksum_acc_next & rrc_pkg::HALF_MASK;
      rrc_pkg::MODE_NONE:  res_checksum = '0;
      default:             res_checksum = checksum_acc_next;
    endcase
    res_crc    = crc_reg_next ^ rrc_pkg::ALL_ONES;
    res_stored = stored_word_next;
    res_match  = (res_checksum == res_stored);

    if (res_status != rrc_pkg::ST_OK) begin
      res_checksum = '0;
      res_crc      = '0;
      res_stored   = '0;
      res_match    = 1'b0;
    end
  end

  // Image state update; the final byte returns it to the reset values.
  always_ff @(posedge clk) begin
    if (rst || (s1_fire && s1_last)) begin
      byte_position <= '0;
      word_assembly <= '0;
      checksum_acc  <= '0;
      crc_reg       <= rrc_pkg::ALL_ONES;
      stored_word   <= '0;
    end else if (s1_fire) begin
      byte_position <= byte_position_next;
      word_assembly <= word_assembly_next;
      checksum_acc  <= checksum_acc_next;
      crc_reg       <= crc_reg_next;
      stored_word   <= stored_word_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      out_checksum <= res_checksum;
      out_crc      <= res_crc;
      out_stored   <= res_stored;
      out_match    <= res_match;
      out_status   <= res_status;
    end
  end

  assign result.valid            = out_valid;
  assign result.checksum_value   = out_checksum;
  assign result.crc_value        = out_crc;
  assign result.stored_value     = out_stored;
  assign result.checksum_matches = out_match;
  assign result.status           = out_status;

  // A final byte leaves the image state at its reset values.
  assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> byte_position == '0 && crc_reg == rrc_pkg::ALL_ONES
      && checksum_acc == '0 && stored_word == '0)
    else $error("image state not cleared after final byte");

  // An error status carries all-zero result values.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != rrc_pkg::ST_OK |-> out_checksum == '0 && out_crc == '0
      && out_stored == '0 && !out_match)
    else $error("error result carries nonzero values");

  // The byte counter saturates just past the address space.
  assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_LIMIT + 1'b1)
    else $error("byte position beyond saturation");

  // A held byte is always a final byte waiting for the result register.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |-> s1_last && out_valid && !result.ready)
    else $error("input register stalled without cause");

  // A result transfer is only issued for a final byte.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_fire && s1_last))
    else $error("result without final byte");

endmodule
